/* hdl/kls_pkg.sv */
// Shared types and constants for the keyframe linear sampler.
`default_nettype none
package kls_pkg;
   localparam int MaxKeysDefault      = 64;
   localparam int FractionBitsDefault = 16;
   localparam int ValueWidth          = 32;
   localparam int RecordWidth         = 4 * ValueWidth;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_CLEAR3 = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_FULL    = 3'd1,
      ST_FALLBK  = 3'd2,
      ST_BEFORE  = 3'd3,
      ST_INTERP  = 3'd4,
      ST_AFTER   = 3'd5,
      ST_CLEARED = 3'd6
   } status_type;

   localparam logic [1:0] CSR_FALLBACK_X = 2'd0;
   localparam logic [1:0] CSR_FALLBACK_Y = 2'd1;
   localparam logic [1:0] CSR_FALLBACK_Z = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_FIRST_CHK,
      S_SCAN,
      S_SCAN_CHK,
      S_PREV,
      S_PREV_WAIT,
      S_DIVIDE,
      S_MUL,
      S_ADD,
      S_LAST,
      S_LAST_WAIT,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

/* hdl/kls_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
`default_nettype none
module kls_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/keyframe_linear_sampler.sv */
// Top level of the keyframe linear sampler: key table, search sequencer and interpolator.
`default_nettype none
// Keys (time, x, y, z) sit in one synchronous RAM, one row per key. One
// item is worked on at a time. Every item ends in a load of the result
// register; append, clear, a full drop and a fallback sample go from the
// taken beat through S_OUT to that load. A sample walks the table one key
// at a time: a RAM read (S_SCAN), then a compare (S_SCAN_CHK). A sample
// at or before the first key is answered from that key alone, and one
// past the last key from the last key once the whole table is walked. An
// interpolated sample scans to the first key later than the query, fetches
// the earlier key, runs the restoring divider for the fraction, then
// multiplies the three components one at a time and adds them to the
// earlier key. The input is stalled only while an item is being worked
// on. A result that waits on rsp_stall does not block the next beat,
// which holds only its own final load until the result register is free.
module keyframe_linear_sampler
   import kls_pkg::*;
#(
   parameter int MAX_KEYS      = MaxKeysDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_key_time,
   input  wire logic [31:0] req_key_x,
   input  wire logic [31:0] req_key_y,
   input  wire logic [31:0] req_key_z,
   input  wire logic [31:0] req_query_time,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_out_x,
   output      logic [31:0] rsp_out_y,
   output      logic [31:0] rsp_out_z,
   output      logic [2:0]  rsp_status,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int FB = FRACTION_BITS;
   localparam int DW = 33 + FB;              // dividend width
   localparam int CNTW = $clog2(DW + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEYS);

   // Configuration registers
   logic [31:0] fb_x_ff, fb_y_ff, fb_z_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_x_ff <= '0;
         fb_y_ff <= '0;
         fb_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FALLBACK_X: fb_x_ff <= csr_data;
            CSR_FALLBACK_Y: fb_y_ff <= csr_data;
            CSR_FALLBACK_Z: fb_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Control and datapath registers
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic signed [31:0] q_ff, q_in;
   logic [RecordWidth-1:0] hi_ff, hi_in;     // later key
   logic [RecordWidth-1:0] lo_ff, lo_in;     // earlier key
   logic [DW-1:0] rem_ff, rem_in;            // dividend shifting out
   logic [32:0] span_ff, span_in;
   logic [FB:0] quo_ff, quo_in;
   logic [32:0] acc_ff, acc_in;               // partial remainder
   logic [CNTW-1:0] dcnt_ff, dcnt_in;
   logic [1:0] comp_ff, comp_in;
   logic signed [32+FB+1:0] prod_ff [3];
   logic signed [32+FB+1:0] prod_in [3];
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   status_type st_ff, st_in;
   status_type res_st_ff, res_st_in;         // status waiting for the result register

   // Key RAM
   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RecordWidth-1:0] ram_wdata, ram_rdata;
   kls_ram #(.Width(RecordWidth), .Depth(MAX_KEYS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   logic accept;
   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   logic signed [31:0] rd_t;
   assign rd_t = ram_rdata[4*32-1:3*32];

   // Lerp helpers
   logic signed [32:0] diff_d;
   logic signed [32+FB+1:0] fsh;
   logic signed [32:0] sum_v;
   logic [33:0] trial;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      quo_in       = quo_ff;
      acc_in       = acc_ff;
      dcnt_in      = dcnt_ff;
      comp_in      = comp_ff;
      prod_in      = prod_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oz_in        = oz_ff;
      st_in        = st_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = {req_key_time, req_key_x, req_key_y, req_key_z};
      ram_raddr    = idx_ff[AW-1:0];
      diff_d       = '0;
      fsh          = '0;
      sum_v        = '0;
      trial        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               q_in = req_query_time;
               lo_in = '0;
               state_in = S_OUT;
               unique case (action_type'(req_action))
                  ACT_APPEND: begin
                     if (count_ff >= FULL_COUNT) begin
                        res_st_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        count_in  = count_ff + 1'b1;
                        res_st_in = ST_STORED;
                     end
                  end
                  ACT_SAMPLE: begin
                     if (count_ff == '0) begin
                        lo_in = {32'd0, fb_x_ff, fb_y_ff, fb_z_ff};
                        res_st_in = ST_FALLBK;
                     end else begin
                        idx_in   = '0;
                        state_in = S_FIRST;
                     end
                  end
                  default: begin
                     count_in = '0;
                     res_st_in = ST_CLEARED;
                  end
               endcase
            end
         end
         S_FIRST: begin
            ram_raddr = '0;
            state_in = S_FIRST_CHK;
         end
         S_FIRST_CHK: begin
            if (q_ff <= rd_t) begin
               lo_in = ram_rdata;
               res_st_in = ST_BEFORE;
               state_in = S_OUT;
            end else begin
               idx_in = CW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff >= count_ff) begin
               idx_in = count_ff - 1'b1;
               state_in = S_LAST;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (q_ff < rd_t) begin
               hi_in = ram_rdata;
               idx_in = idx_ff - 1'b1;
               state_in = S_PREV;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_PREV: begin
            state_in = S_PREV_WAIT;
         end
         S_PREV_WAIT: begin
            logic signed [32:0] sp;
            logic signed [32:0] nm;
            sp = 33'(signed'(hi_ff[127:96])) - 33'(signed'(ram_rdata[127:96]));
            nm = 33'(q_ff) - 33'(signed'(ram_rdata[127:96]));
            lo_in = ram_rdata;
            span_in = sp;
            rem_in = {nm, {FB{1'b0}}};
            acc_in = '0;
            quo_in = '0;
            dcnt_in = CNTW'(DW);
            if (sp > 0 && !nm[32]) begin
               state_in = S_DIVIDE;
            end else begin
               comp_in = '0;
               state_in = S_MUL;
            end
         end
         S_DIVIDE: begin
            // restoring divide, one quotient bit a cycle
            trial = {acc_ff, rem_ff[DW-1]} - {1'b0, span_ff};
            rem_in = rem_ff << 1;
            if (!trial[33]) begin
               acc_in = trial[32:0];
               quo_in = {quo_ff[FB-1:0], 1'b1};
            end else begin
               acc_in = {acc_ff[31:0], rem_ff[DW-1]};
               quo_in = {quo_ff[FB-1:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == CNTW'(1)) begin
               comp_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // one component per cycle
            logic [31:0] a, b;
            unique case (comp_ff)
               2'd0: begin a = lo_ff[95:64]; b = hi_ff[95:64]; end
               2'd1: begin a = lo_ff[63:32]; b = hi_ff[63:32]; end
               default: begin a = lo_ff[31:0]; b = hi_ff[31:0]; end
            endcase
            diff_d = 33'(signed'(b)) - 33'(signed'(a));
            prod_in[comp_ff] = (34+FB)'(diff_d) *
                               (34+FB)'(signed'({1'b0, (quo_ff[FB] ? {FB{1'b1}} : quo_ff[FB-1:0])}));
            if (comp_ff == 2'd2) begin
               state_in = S_ADD;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         S_ADD: begin
            fsh = prod_ff[0] >>> FB;
            sum_v = 33'(signed'(lo_ff[95:64])) + fsh[32:0];
            ox_in = sum_v[31:0];
            fsh = prod_ff[1] >>> FB;
            sum_v = 33'(signed'(lo_ff[63:32])) + fsh[32:0];
            oy_in = sum_v[31:0];
            fsh = prod_ff[2] >>> FB;
            sum_v = 33'(signed'(lo_ff[31:0])) + fsh[32:0];
            oz_in = sum_v[31:0];
            st_in = ST_INTERP;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LAST: begin
            state_in = S_LAST_WAIT;
         end
         S_LAST_WAIT: begin
            lo_in = ram_rdata;
            res_st_in = ST_AFTER;
            state_in = S_OUT;
         end
         S_OUT: begin
            ox_in = lo_ff[95:64];
            oy_in = lo_ff[63:32];
            oz_in = lo_ff[31:0];
            st_in = res_st_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // result register holds while stalled
      if (rsp_valid_ff && rsp_stall) begin
         ox_in = ox_ff;
         oy_in = oy_ff;
         oz_in = oz_ff;
         st_in = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      q_ff      <= q_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      rem_ff    <= rem_in;
      span_ff   <= span_in;
      quo_ff    <= quo_in;
      acc_ff    <= acc_in;
      dcnt_ff   <= dcnt_in;
      comp_ff   <= comp_in;
      prod_ff   <= prod_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oz_ff     <= oz_in;
      st_ff     <= st_in;
      res_st_ff <= res_st_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = ox_ff;
   assign rsp_out_y  = oy_ff;
   assign rsp_out_z  = oz_ff;
   assign rsp_status = st_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("key count beyond table size");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("input taken while busy");
   a_zero_nonsample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_STORED || rsp_status == ST_FULL ||
                    rsp_status == ST_CLEARED) |-> rsp_out_x == '0 && rsp_out_z == '0)
      else $error("non-sample result carries a value");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_action[1] |=> count_ff == '0) else $error("clear did not empty table");
endmodule
`default_nettype wire
